>>> design/gha_pkg.sv
package gha_pkg;

    // Sizes of the slot space and the handle fields
    localparam int SLOTS   = 128;
    localparam int SLOT_W  = 7;
    localparam int GEN_W   = 16;
    localparam int CNT_W   = 8;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_FULL    = 2'd2,
        ST_STALE   = 2'd3
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [SLOT_W-1:0]  slot;
        logic [GEN_W-1:0]   gen;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> design/generational_handle_allocator.sv
// Sequence: an accepted item waits in the two-entry command queue, then the back end pops it
// and steps through its stack read, generation read (plus a slot 0 read for a stale query)
// and result hand-off steps, raising out_valid once the result is registered.
// The back end takes no new command until the result is taken; the queue accepts meanwhile.
// Reset (rst_n, async, active low): every slot free, stack entry i holds i,
// all generations zero, queue empty; per-entry valid bits make this immediate.
module generational_handle_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic [gha_pkg::SLOT_W-1:0] slot_in,
    input  logic [gha_pkg::GEN_W-1:0]  gen_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gha_pkg::SLOT_W-1:0] slot_out,
    output logic [gha_pkg::GEN_W-1:0]  gen_out,
    output logic [1:0]                 status,
    output logic [gha_pkg::CNT_W-1:0]  live_count
);
    import gha_pkg::*;

    q_ctrl_t q_ctrl;
    q_stat_t q_stat;
    cmd_t    q_wdata;
    cmd_t    q_rdata;
    logic    q_push;
    logic    q_pop;

    assign q_ctrl.push = q_push;
    assign q_ctrl.pop  = q_pop;

    // Accept and classify items
    gha_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .slot_in  (slot_in),
        .gen_in   (gen_in),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // Buffer commands between front and back
    gha_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .wdata (q_wdata),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    // Carry out commands against the free stack and generation table
    gha_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_rdata    (q_rdata),
        .q_stat     (q_stat),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .slot_out   (slot_out),
        .gen_out    (gen_out),
        .status     (status),
        .live_count (live_count)
    );

endmodule

>>> design/gha_front.sv
module gha_front (
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                op,
    input  logic [gha_pkg::SLOT_W-1:0] slot_in,
    input  logic [gha_pkg::GEN_W-1:0]  gen_in,
    input  gha_pkg::q_stat_t          q_stat,
    output logic                      q_push,
    output gha_pkg::cmd_t             q_wdata
);
    import gha_pkg::*;

    op_t kind;

    // Accept an item whenever the queue has room
    assign in_ready = !q_stat.full;
    assign q_push   = in_valid && !q_stat.full;

    // Classify the operation; only a query carries a generation onward
    always_comb
    begin
        kind = op_t'(op);
        q_wdata.op   = kind;
        q_wdata.slot = '0;
        q_wdata.gen  = '0;
        unique case (kind)
            OP_ALLOC:
            begin
            end
            OP_RELEASE:
            begin
                q_wdata.slot = slot_in;
            end
            OP_QUERY:
            begin
                q_wdata.slot = slot_in;
                q_wdata.gen  = gen_in;
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> design/gha_queue.sv
module gha_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  gha_pkg::q_ctrl_t   ctrl,
    input  gha_pkg::cmd_t      wdata,
    output gha_pkg::cmd_t      rdata,
    output gha_pkg::q_stat_t   stat
);
    import gha_pkg::*;

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = ctrl.push && !stat.full;
    assign do_pop     = ctrl.pop && !stat.empty;
    assign rdata      = mem_reg[rd_ptr_reg];

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> design/gha_back.sv
module gha_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gha_pkg::cmd_t              q_rdata,
    input  gha_pkg::q_stat_t           q_stat,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gha_pkg::SLOT_W-1:0] slot_out,
    output logic [gha_pkg::GEN_W-1:0]  gen_out,
    output logic [1:0]                 status,
    output logic [gha_pkg::CNT_W-1:0]  live_count
);
    import gha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STK,
        S_GEN,
        S_G0,
        S_OUT
    } state_t;

    state_t             state_reg;
    cmd_t               cmd_reg;
    logic [CNT_W-1:0]   free_count_reg;
    logic [CNT_W-1:0]   free_count_next;
    logic [SLOTS-1:0]   stk_vld_reg;
    logic [SLOTS-1:0]   gen_vld_reg;
    logic               stk_hit_reg;
    logic               gen_hit_reg;
    logic [SLOT_W-1:0]  stk_top_reg;
    logic [SLOT_W-1:0]  stk_rdata_reg;
    logic [GEN_W-1:0]   gen_rdata_reg;
    logic [SLOT_W-1:0]  slot_out_reg;
    logic [GEN_W-1:0]   gen_out_reg;
    status_t            status_reg;
    logic [CNT_W-1:0]   live_reg;
    logic               out_valid_reg;

    logic [SLOT_W-1:0]  stk_mem [SLOTS];
    logic [GEN_W-1:0]   gen_mem [SLOTS];

    logic [CNT_W-1:0]   top_wide;
    logic [SLOT_W-1:0]  stk_top;
    logic [SLOT_W-1:0]  gen_raddr;
    logic [SLOT_W-1:0]  stk_q;
    logic [GEN_W-1:0]   gen_q;
    logic [GEN_W-1:0]   gen_inc;
    logic               stk_we;
    logic               gen_we;
    logic               need_g0;
    logic [SLOT_W-1:0]  res_slot;
    logic [GEN_W-1:0]   res_gen;
    status_t            res_status;

    assign top_wide  = free_count_reg - 1'b1;
    assign stk_top   = top_wide[SLOT_W-1:0];
    assign stk_q     = stk_hit_reg ? stk_rdata_reg : stk_top_reg;
    assign gen_q     = gen_hit_reg ? gen_rdata_reg : '0;
    assign gen_inc   = gen_q + 1'b1;
    assign q_pop     = (state_reg == S_IDLE) && !q_stat.empty;

    // Pick the generation address: the popped slot, the handle slot, or slot 0
    always_comb
    begin
        gen_raddr = cmd_reg.slot;
        if (state_reg == S_GEN)
        begin
            gen_raddr = '0;
        end
        else if (cmd_reg.op == OP_ALLOC)
        begin
            gen_raddr = stk_q;
        end
    end

    // Execute the command once both reads are back
    always_comb
    begin
        free_count_next = free_count_reg;
        stk_we     = 1'b0;
        gen_we     = 1'b0;
        need_g0    = 1'b0;
        res_slot   = '0;
        res_gen    = '0;
        res_status = ST_OK;
        unique case (cmd_reg.op)
            OP_ALLOC:
            begin
                if (free_count_reg == '0)
                begin
                    res_status = ST_NO_FREE;
                end
                else
                begin
                    free_count_next = free_count_reg - 1'b1;
                    res_slot = stk_q;
                    res_gen  = gen_q;
                end
            end
            OP_RELEASE:
            begin
                res_slot = cmd_reg.slot;
                if (free_count_reg == SLOTS_CNT)
                begin
                    res_gen    = gen_q;
                    res_status = ST_FULL;
                end
                else
                begin
                    free_count_next = free_count_reg + 1'b1;
                    stk_we  = 1'b1;
                    gen_we  = 1'b1;
                    res_gen = gen_inc;
                end
            end
            OP_QUERY:
            begin
                if (gen_q == cmd_reg.gen)
                begin
                    res_slot = cmd_reg.slot;
                    res_gen  = gen_q;
                end
                else
                begin
                    need_g0 = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (state_reg != S_GEN)
        begin
            free_count_next = free_count_reg;
            stk_we  = 1'b0;
            gen_we  = 1'b0;
            need_g0 = 1'b0;
        end
    end

    // Stack and generation memories with registered reads
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[free_count_reg[SLOT_W-1:0]] <= cmd_reg.slot;
        end
        if (gen_we)
        begin
            gen_mem[cmd_reg.slot] <= gen_inc;
        end
        stk_rdata_reg <= stk_mem[stk_top];
        gen_rdata_reg <= gen_mem[gen_raddr];
    end

    // Sequence the command and hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_count_reg <= SLOTS_CNT;
            stk_vld_reg    <= '0;
            gen_vld_reg    <= '0;
            stk_hit_reg    <= 1'b0;
            gen_hit_reg    <= 1'b0;
            stk_top_reg    <= '0;
            out_valid_reg  <= 1'b0;
            cmd_reg        <= '0;
            slot_out_reg   <= '0;
            gen_out_reg    <= '0;
            status_reg     <= ST_OK;
            live_reg       <= '0;
        end
        else
        begin
            stk_hit_reg <= stk_vld_reg[stk_top];
            stk_top_reg <= stk_top;
            gen_hit_reg <= gen_vld_reg[gen_raddr];
            free_count_reg <= free_count_next;
            if (stk_we)
            begin
                stk_vld_reg[free_count_reg[SLOT_W-1:0]] <= 1'b1;
            end
            if (gen_we)
            begin
                gen_vld_reg[cmd_reg.slot] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        cmd_reg   <= q_rdata;
                        state_reg <= S_STK;
                    end
                end
                S_STK:
                begin
                    state_reg <= S_GEN;
                end
                S_GEN:
                begin
                    if (need_g0)
                    begin
                        state_reg <= S_G0;
                    end
                    else
                    begin
                        slot_out_reg  <= res_slot;
                        gen_out_reg   <= res_gen;
                        status_reg    <= res_status;
                        live_reg      <= SLOTS_CNT - free_count_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_G0:
                begin
                    slot_out_reg  <= '0;
                    gen_out_reg   <= gen_q;
                    status_reg    <= ST_STALE;
                    live_reg      <= SLOTS_CNT - free_count_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign slot_out   = slot_out_reg;
    assign gen_out    = gen_out_reg;
    assign status     = status_reg;
    assign live_count = live_reg;

endmodule

>>> design/gha_checker.sv
module gha_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic [gha_pkg::SLOT_W-1:0] slot_in,
    input  logic [gha_pkg::GEN_W-1:0]  gen_in,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [gha_pkg::SLOT_W-1:0] slot_out,
    input  logic [gha_pkg::GEN_W-1:0]  gen_out,
    input  logic [1:0]                 status,
    input  logic [gha_pkg::CNT_W-1:0]  live_count
);
    import gha_pkg::*;

    // Hold a waiting input item
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(op) && $stable(slot_in)
            && $stable(gen_in))
        else $error("input item changed while waiting");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot_out) && $stable(gen_out)
            && $stable(status) && $stable(live_count))
        else $error("result changed while stalled");

    // Empty allocate only when every slot is live
    a_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NO_FREE) |-> (live_count == SLOTS_CNT) && (slot_out == '0))
        else $error("no-free status with slots still free");

    // Full release only when nothing is live
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (live_count == '0))
        else $error("full status with live slots");

    // Live count never exceeds the slot count, and a stale query reports slot 0
    a_stale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (live_count <= SLOTS_CNT) && ((status != ST_STALE) || (slot_out == '0)))
        else $error("bad live count or stale slot");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (.*);

>>> bench/tb_top.sv
module tb_top;
    import gha_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_ITEMS  = 100;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [GEN_W-1:0]  gen;
        status_t           status;
        logic [CNT_W-1:0]  live;
    } handle_result_t;

    typedef struct {
        op_t               kind;
        logic [SLOT_W-1:0] slot;
        logic [GEN_W-1:0]  gen;
        bit                typed;
        handle_result_t    want;
    } directed_row_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [1:0]          op         = OP_NONE;
    logic [SLOT_W-1:0]   slot_in    = '0;
    logic [GEN_W-1:0]    gen_in     = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [SLOT_W-1:0]   slot_out;
    logic [GEN_W-1:0]    gen_out;
    logic [1:0]          status;
    logic [CNT_W-1:0]    live_count;

    // Shadow copy of the allocator state
    logic [SLOT_W-1:0]   free_slots [SLOTS];
    logic [CNT_W-1:0]    free_cnt;
    logic [GEN_W-1:0]    slot_gen [SLOTS];

    handle_result_t      pending_results [$];
    int                  mismatches = 0;
    int                  idle_pct   = 0;
    bit                  quiet      = 1'b0;
    int                  ready_hold = 0;

    generational_handle_allocator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .slot_in    (slot_in),
        .gen_in     (gen_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .slot_out   (slot_out),
        .gen_out    (gen_out),
        .status     (status),
        .live_count (live_count)
    );

    always #2 clk = ~clk;

    // Apply one operation to the shadow state and return the result it gives.
    // Every 7-bit slot number is below SLOTS, so no range check is needed.
    function automatic handle_result_t apply_handle_op(input op_t kind,
                                                       input logic [SLOT_W-1:0] s,
                                                       input logic [GEN_W-1:0] g);
        handle_result_t r;
        r.slot   = '0;
        r.gen    = '0;
        r.status = ST_OK;
        case (kind)
            OP_ALLOC:
            begin
                if (free_cnt == 0)
                    r.status = ST_NO_FREE;
                else
                begin
                    free_cnt = free_cnt - 1'b1;
                    r.slot   = free_slots[free_cnt];
                    r.gen    = slot_gen[r.slot];
                end
            end
            OP_RELEASE:
            begin
                r.slot = s;
                if (free_cnt == SLOTS_CNT)
                begin
                    r.gen    = slot_gen[s];
                    r.status = ST_FULL;
                end
                else
                begin
                    // double release is not caught: push and bump anyway
                    free_slots[free_cnt] = s;
                    free_cnt             = free_cnt + 1'b1;
                    slot_gen[s]          = slot_gen[s] + 1'b1;
                    r.gen                = slot_gen[s];
                end
            end
            OP_QUERY:
            begin
                if (slot_gen[s] == g)
                begin
                    r.slot = s;
                    r.gen  = slot_gen[s];
                end
                else
                begin
                    r.gen    = slot_gen[0];
                    r.status = ST_STALE;
                end
            end
            default:
            begin
            end
        endcase
        r.live = SLOTS_CNT - free_cnt;
        return r;
    endfunction

    function automatic directed_row_t mk_row(input op_t kind, input int s, input int g,
                                             input bit typed, input int ws, input int wg,
                                             input status_t wst, input int wl);
        directed_row_t row;
        row.kind        = kind;
        row.slot        = SLOT_W'(s);
        row.gen         = GEN_W'(g);
        row.typed       = typed;
        row.want.slot   = SLOT_W'(ws);
        row.want.gen    = GEN_W'(wg);
        row.want.status = wst;
        row.want.live   = CNT_W'(wl);
        return row;
    endfunction

    task automatic flag_error(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", what);
    endtask

    // Offer one item, wait for it to be taken, then log its expected result
    task automatic send_item(input op_t kind, input logic [SLOT_W-1:0] s,
                             input logic [GEN_W-1:0] g, input bit typed,
                             input handle_result_t want);
        handle_result_t got;
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= kind;
        slot_in  <= s;
        gen_in   <= g;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = apply_handle_op(kind, s, g);
        pending_results.push_back(typed ? want : got);
    endtask

    // Stall the result side in random bursts
    always @(posedge clk)
    begin
        if (quiet)
            ready_hold = 0;
        else if (ready_hold == 0 && $urandom_range(0, 199) < idle_pct)
            ready_hold = $urandom_range(1, 17);
        if (ready_hold > 0)
        begin
            ready_hold = ready_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin : check_results
        handle_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                flag_error($sformatf("unexpected result: slot %0d gen %0h status %0d live %0d",
                                     slot_out, gen_out, status, live_count));
            else
            begin
                want = pending_results.pop_front();
                if (slot_out !== want.slot || gen_out !== want.gen ||
                    status !== want.status || live_count !== want.live)
                    flag_error($sformatf({"mismatch (expected/actual): slot %0d/%0d ",
                                          "gen %0h/%0h status %0d/%0d live %0d/%0d"},
                                         want.slot, slot_out, want.gen, gen_out,
                                         want.status, status, want.live, live_count));
            end
        end
    end

    initial
    begin : stimulus
        directed_row_t     rows [$];
        handle_result_t    no_result;
        bit                on_stack [SLOTS];
        logic [SLOT_W-1:0] live_q [$];
        int                issued;
        int                pick;
        bit                filling;
        op_t               kind;
        logic [SLOT_W-1:0] s;
        logic [GEN_W-1:0]  g;

        no_result = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            free_slots[i] = SLOT_W'(i);
            slot_gen[i]   = '0;
        end
        free_cnt = SLOTS_CNT;

        // Hold reset low before releasing it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset state, stale and full cases, reuse of a slot, double release
        rows.push_back(mk_row(OP_QUERY,     0,      0, 1,   0, 0, ST_OK,    0));
        rows.push_back(mk_row(OP_QUERY,   127, 'hFFFF, 1,   0, 0, ST_STALE, 0));
        rows.push_back(mk_row(OP_RELEASE,   5,      0, 1,   5, 0, ST_FULL,  0));
        rows.push_back(mk_row(OP_NONE,    127, 'hFFFF, 1,   0, 0, ST_OK,    0));
        rows.push_back(mk_row(OP_ALLOC,     0,      0, 1, 127, 0, ST_OK,    1));
        rows.push_back(mk_row(OP_QUERY,   127,      0, 1, 127, 0, ST_OK,    1));
        rows.push_back(mk_row(OP_RELEASE, 127,      0, 1, 127, 1, ST_OK,    0));
        rows.push_back(mk_row(OP_QUERY,   127,      0, 1,   0, 0, ST_STALE, 0));
        rows.push_back(mk_row(OP_QUERY,   127,      1, 1, 127, 1, ST_OK,    0));
        rows.push_back(mk_row(OP_ALLOC,     0,      0, 1, 127, 1, ST_OK,    1));
        rows.push_back(mk_row(OP_ALLOC,     0,      0, 1, 126, 0, ST_OK,    2));
        rows.push_back(mk_row(OP_RELEASE, 126,      0, 1, 126, 1, ST_OK,    1));
        rows.push_back(mk_row(OP_RELEASE, 126,      0, 1, 126, 2, ST_OK,    0));
        rows.push_back(mk_row(OP_QUERY,   127, 'h8000, 1,   0, 0, ST_STALE, 0));
        rows.push_back(mk_row(OP_NONE,      0,      0, 1,   0, 0, ST_OK,    0));
        rows.push_back(mk_row(OP_ALLOC,   127, 'hFFFF, 0,   0, 0, ST_OK,    0));
        rows.push_back(mk_row(OP_RELEASE,   3, 'h5555, 0,   0, 0, ST_OK,    0));
        rows.push_back(mk_row(OP_QUERY,     3,      1, 0,   0, 0, ST_OK,    0));
        rows.push_back(mk_row(OP_QUERY,     0,      0, 0,   0, 0, ST_OK,    0));
        foreach (rows[i])
            send_item(rows[i].kind, rows[i].slot, rows[i].gen, rows[i].typed, rows[i].want);

        // Random: sweep between empty and full, mostly on live handles
        filling = 1'b1;
        issued  = 0;
        while (issued < RANDOM_ITEMS)
        begin
            if (issued % 100 == 0)
            begin
                pick     = $urandom_range(0, 2);
                idle_pct = (pick == 0) ? 0 : ((pick == 1) ? 10 : 30);
            end
            quiet = (issued >= RANDOM_ITEMS - QUIET_ITEMS);

            // turn around a few items after hitting an extreme
            if (filling && free_cnt == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && free_cnt == SLOTS_CNT && $urandom_range(0, 3) == 0)
                filling = 1'b1;

            live_q.delete();
            for (int i = 0; i < SLOTS; i++)
                on_stack[i] = 1'b0;
            for (int i = 0; i < free_cnt; i++)
                on_stack[free_slots[i]] = 1'b1;
            for (int i = 0; i < SLOTS; i++)
                if (!on_stack[i])
                    live_q.push_back(SLOT_W'(i));

            s    = SLOT_W'($urandom_range(0, SLOTS - 1));
            g    = GEN_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                kind = OP_NONE;
            else if (pick < 6)
                kind = op_t'($urandom_range(0, 3));
            else
            begin
                pick = $urandom_range(0, 99);
                if (filling)
                    kind = (pick < 80) ? OP_ALLOC : ((pick < 90) ? OP_RELEASE : OP_QUERY);
                else
                    kind = (pick < 15) ? OP_ALLOC : ((pick < 85) ? OP_RELEASE : OP_QUERY);
                if (live_q.size() > 0)
                begin
                    pick = $urandom_range(0, 99);
                    if (kind == OP_RELEASE && pick < 90)
                        s = live_q[$urandom_range(0, live_q.size() - 1)];
                    else if (kind == OP_QUERY && pick < 60)
                    begin
                        s = live_q[$urandom_range(0, live_q.size() - 1)];
                        g = slot_gen[s];
                    end
                    else if (kind == OP_QUERY && pick < 80)
                    begin
                        // recent stale handle: right slot, a slightly later generation
                        s = live_q[$urandom_range(0, live_q.size() - 1)];
                        g = slot_gen[s] + GEN_W'($urandom_range(1, 3));
                    end
                end
            end
            if (kind != OP_NONE)
                issued++;
            send_item(kind, s, g, 1'b0, no_result);
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then allow for any trailing output
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS generational_handle_allocator");
        else
            $display("FAIL generational_handle_allocator");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #2000000;
        $display("FAIL generational_handle_allocator");
        $finish;
    end

endmodule

>>> sim.f
design/gha_pkg.sv
design/gha_front.sv
design/gha_queue.sv
design/gha_back.sv
design/generational_handle_allocator.sv
design/gha_checker.sv
bench/tb_top.sv
